FILE: rtl/c420ba_pkg.sv
// Shared types and constants for the 4:2:0 chroma box-average core.
// No dependencies; used by every module of the block.
package c420ba_pkg;

   // Fixed field widths and size limits
   localparam int SAMPLE_W    = 8;
   localparam int COORD_W     = 11;
   localparam int SIZE_W      = 12;
   localparam int COUNT_LIMIT = 2048;
   localparam int MAX_HEIGHT  = 2048;

   // Configuration register map
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = SIZE_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // Input transaction
   typedef struct packed {
      logic [SAMPLE_W-1:0] y_in;
      logic [SAMPLE_W-1:0] u_in;
      logic [SAMPLE_W-1:0] v_in;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [COORD_W-1:0]  out_col;
      logic [COORD_W-1:0]  out_row;
      logic [SAMPLE_W-1:0] y_out;
      logic [SAMPLE_W-1:0] u_out;
      logic [SAMPLE_W-1:0] v_out;
      logic                last_of_block;
   } rsp_type;

   // Pixel as kept in the line store
   typedef struct packed {
      logic [SAMPLE_W-1:0] v;
      logic [SAMPLE_W-1:0] u;
      logic [SAMPLE_W-1:0] y;
   } pix_type;

   localparam int PIX_W = $bits(pix_type);

   // One pixel of a finished block
   typedef struct packed {
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [SAMPLE_W-1:0] y;
   } slot_type;

   // Finished block handed to the emitter (count 0 means nothing to send)
   typedef struct packed {
      slot_type [3:0]      slot;
      logic [SAMPLE_W-1:0] u_avg;
      logic [SAMPLE_W-1:0] v_avg;
      logic [2:0]          count;
   } block_type;

endpackage

FILE: rtl/c420ba_line_store.sv
// Line store: single-port synchronous RAM holding the even row of a row pair.
// Depends on c420ba_pkg for the pixel width.
module c420ba_line_store #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            addr,
   input  logic [c420ba_pkg::PIX_W-1:0] wr_data,
   output logic [c420ba_pkg::PIX_W-1:0] rd_data
);

   logic [c420ba_pkg::PIX_W-1:0] mem [DEPTH];
   logic [c420ba_pkg::PIX_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // Registered read, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/c420ba_emit.sv
// Result emitter: holds one finished block and sends its pixels one per cycle while rsp_stall is low.
// Depends on c420ba_pkg for block_type and rsp_type.
module c420ba_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  c420ba_pkg::block_type blk,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output c420ba_pkg::rsp_type   rsp_data
);

   logic                  em_valid_ff, em_valid_in;
   logic [1:0]            idx_ff, idx_in;
   c420ba_pkg::block_type blk_ff;
   c420ba_pkg::slot_type  cur_slot;
   logic                  last_beat;
   logic                  beat_done;
   logic                  blk_done;

   assign cur_slot  = blk_ff.slot[idx_ff];
   assign last_beat = ({1'b0, idx_ff} == (blk_ff.count - 3'd1));
   assign beat_done = em_valid_ff && !rsp_stall;
   assign blk_done  = beat_done && last_beat;
   assign free      = !em_valid_ff || blk_done;

   // Beat sequencing
   always_comb begin
      em_valid_in = em_valid_ff;
      idx_in      = idx_ff;
      if (load) begin
         em_valid_in = (blk.count != 3'd0);
         idx_in      = 2'd0;
      end else if (blk_done) begin
         em_valid_in = 1'b0;
      end else if (beat_done) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         idx_ff      <= 2'd0;
      end else begin
         em_valid_ff <= em_valid_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         blk_ff <= blk;
      end
   end

   // Output transaction
   assign rsp_valid              = em_valid_ff;
   assign rsp_data.out_col       = cur_slot.col;
   assign rsp_data.out_row       = cur_slot.row;
   assign rsp_data.y_out         = cur_slot.y;
   assign rsp_data.u_out         = blk_ff.u_avg;
   assign rsp_data.v_out         = blk_ff.v_avg;
   assign rsp_data.last_of_block = last_beat;

endmodule

FILE: rtl/chroma_420_block_average_core.sv
// Top level of the 4:2:0 chroma box-average core: counters, line store, block math.
// Depends on c420ba_pkg, c420ba_line_store and c420ba_emit.
//
// Pixels enter in raster order; results leave block by block (top-left,
// top-right, bottom-left, bottom-right) with U and V set to the floor of the
// 2x2 average. A pixel is read from or written to the line store in the cycle
// it is accepted and its block is formed in the next cycle from the stage 1
// registers; the first result of a block leaves the emitter register once
// stage 1 has drained into a free emitter. Even rows run at one pixel per
// cycle while the emitter is free. On odd rows each full block sends four
// result beats on the single result port, and the even-column pixel passes
// the idle emitter; a one-row-high last row sends two beats per pair. A result
// stall keeps the emitter busy and stalls the input. The line store needs no
// clearing pass: every entry read was written on the row above. frame_width
// saturates to the smaller of 2048 and MAX_WIDTH, frame_height to 2048.
module chroma_420_block_average_core #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [c420ba_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [c420ba_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  c420ba_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output c420ba_pkg::rsp_type                    rsp_data
);

   localparam int WIDTH_LIMIT  = (MAX_WIDTH < c420ba_pkg::COUNT_LIMIT) ?
                                 MAX_WIDTH : c420ba_pkg::COUNT_LIMIT;
   localparam int HEIGHT_LIMIT = (c420ba_pkg::MAX_HEIGHT < c420ba_pkg::COUNT_LIMIT) ?
                                 c420ba_pkg::MAX_HEIGHT : c420ba_pkg::COUNT_LIMIT;
   localparam int ADDR_W       = (WIDTH_LIMIT > 1) ? $clog2(WIDTH_LIMIT) : 1;
   localparam int CW           = c420ba_pkg::COORD_W;
   localparam int SW           = c420ba_pkg::SIZE_W;

   // Configuration and frame position
   logic [SW-1:0]       fw_ff, fh_ff;
   logic [CW-1:0]       col_ff, col_in, row_ff, row_in;
   c420ba_pkg::pix_type left_ff;

   // Stage 1: accepted pixel waiting for its line store read
   logic                s1_valid_ff, s1_valid_in;
   c420ba_pkg::pix_type s1_cur_ff, s1_left_ff, tl_ff;
   logic [CW-1:0]       s1_col_ff, s1_row_ff;
   logic                s1_last_col_ff, s1_last_row_ff;

   logic [SW-1:0]       w_eff, h_eff;
   logic                last_col, last_row;
   logic                accept;
   logic                s1_adv;
   logic                em_free;
   c420ba_pkg::pix_type cur_pix, top_pix;
   logic [ADDR_W-1:0]   ls_addr;
   logic                ls_wr_en, ls_rd_en;
   c420ba_pkg::block_type blk;

   // Effective frame size, zero taken as one, saturated to the limits
   always_comb begin
      w_eff = fw_ff;
      if (fw_ff == '0) begin
         w_eff = SW'(1);
      end else if (fw_ff > SW'(WIDTH_LIMIT)) begin
         w_eff = SW'(WIDTH_LIMIT);
      end
      h_eff = fh_ff;
      if (fh_ff == '0) begin
         h_eff = SW'(1);
      end else if (fh_ff > SW'(HEIGHT_LIMIT)) begin
         h_eff = SW'(HEIGHT_LIMIT);
      end
   end

   assign last_col = (({1'b0, col_ff} + SW'(1)) >= w_eff);
   assign last_row = (({1'b0, row_ff} + SW'(1)) >= h_eff);

   // Handshake: stage 1 drains only into a free emitter
   assign s1_adv    = s1_valid_ff && em_free;
   assign req_stall = s1_valid_ff && !em_free;
   assign accept    = req_valid && !req_stall;

   assign cur_pix.y = req_data.y_in;
   assign cur_pix.u = req_data.u_in;
   assign cur_pix.v = req_data.v_in;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= c420ba_pkg::FRAME_WIDTH_RESET;
         fh_ff <= c420ba_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            c420ba_pkg::CSR_FRAME_WIDTH:  fw_ff <= csr_wdata;
            c420ba_pkg::CSR_FRAME_HEIGHT: fh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            left_ff <= cur_pix;
         end
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff      <= cur_pix;
         s1_left_ff     <= left_ff;
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
      end
      // the top pixel of the previous column becomes the top-left
      if (s1_adv) begin
         tl_ff <= top_pix;
      end
   end

   // Line store access: odd rows read, even rows above another row write
   always_comb begin
      if (col_ff > CW'(WIDTH_LIMIT - 1)) begin
         ls_addr = ADDR_W'(WIDTH_LIMIT - 1);
      end else begin
         ls_addr = ADDR_W'(col_ff);
      end
   end

   assign ls_rd_en = accept && row_ff[0];
   assign ls_wr_en = accept && !row_ff[0] && !last_row;

   c420ba_line_store #(
      .DEPTH  (WIDTH_LIMIT),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ls_wr_en),
      .rd_en   (ls_rd_en),
      .addr    (ls_addr),
      .wr_data (cur_pix),
      .rd_data (top_pix)
   );

   // Block formation: pick the four sum operands and the pixels to send
   always_comb begin
      logic                        odd_row, odd_col;
      logic [CW-1:0]               col_m1, row_m1;
      c420ba_pkg::pix_type         a, b, c, d;
      logic [c420ba_pkg::SAMPLE_W+1:0] su, sv;

      odd_row = s1_row_ff[0];
      odd_col = s1_col_ff[0];
      col_m1  = s1_col_ff - CW'(1);
      row_m1  = s1_row_ff - CW'(1);
      a = s1_cur_ff;
      b = s1_cur_ff;
      c = s1_cur_ff;
      d = s1_cur_ff;
      blk.count = 3'd0;
      for (int i = 0; i < 4; i++) begin
         blk.slot[i].col = s1_col_ff;
         blk.slot[i].row = s1_row_ff;
         blk.slot[i].y   = s1_cur_ff.y;
      end

      if (odd_row && odd_col) begin
         // full 2x2 block
         a = tl_ff;
         b = top_pix;
         c = s1_left_ff;
         blk.count = 3'd4;
         blk.slot[0].col = col_m1;
         blk.slot[0].row = row_m1;
         blk.slot[0].y   = tl_ff.y;
         blk.slot[1].row = row_m1;
         blk.slot[1].y   = top_pix.y;
         blk.slot[2].col = col_m1;
         blk.slot[2].y   = s1_left_ff.y;
      end else if (odd_row && s1_last_col_ff) begin
         // one column wide: top and bottom each count twice
         a = top_pix;
         b = top_pix;
         blk.count = 3'd2;
         blk.slot[0].row = row_m1;
         blk.slot[0].y   = top_pix.y;
      end else if (!odd_row && s1_last_row_ff && odd_col) begin
         // one row high: left and current each count twice
         a = s1_left_ff;
         b = s1_left_ff;
         blk.count = 3'd2;
         blk.slot[0].col = col_m1;
         blk.slot[0].y   = s1_left_ff.y;
      end else if (!odd_row && s1_last_row_ff && s1_last_col_ff) begin
         // lone corner pixel
         blk.count = 3'd1;
      end

      su = 10'(a.u) + 10'(b.u) + 10'(c.u) + 10'(d.u);
      sv = 10'(a.v) + 10'(b.v) + 10'(c.v) + 10'(d.v);
      blk.u_avg = su[9:2];
      blk.v_avg = sv[9:2];
   end

   c420ba_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_adv),
      .blk       (blk),
      .free      (em_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/c420ba_checker.sv
// Port-level checker for the 4:2:0 chroma box-average core, bound to the top.
// Depends on c420ba_pkg and chroma_420_block_average_core.
module c420ba_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input c420ba_pkg::rsp_type rsp_data
);

   logic rsp_mid_block;

   assign rsp_mid_block = rsp_valid && !rsp_stall && !rsp_data.last_of_block;

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Rest of a block is buffered, so it follows without a gap
   a_block_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_mid_block |=> rsp_valid)
      else $error("gap inside a block");

   // All pixels of a block share one chroma pair
   a_block_chroma: assert property (@(posedge clock) disable iff (reset)
      rsp_mid_block |=> rsp_data.u_out == $past(rsp_data.u_out) &&
                        rsp_data.v_out == $past(rsp_data.v_out))
      else $error("chroma changed inside a block");

   // Within a block rows stay or step down by one
   a_block_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_mid_block |=> rsp_data.out_row == $past(rsp_data.out_row) ||
                        rsp_data.out_row == $past(rsp_data.out_row) + 11'd1)
      else $error("row jump inside a block");

endmodule

bind chroma_420_block_average_core c420ba_checker u_c420ba_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/chroma_420_block_average_core_check.sv
// Result checker for the 4:2:0 chroma box-average core: tracks the frame
// registers, predicts every block from accepted pixels and compares results.
// Depends on c420ba_pkg.
`timescale 1ns / 100ps

module chroma_420_block_average_core_check #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [c420ba_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [c420ba_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  c420ba_pkg::req_type               req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  c420ba_pkg::rsp_type               rsp_data,
   output int                                fail_count,
   output int                                pending_results
);

   localparam int BLOCK_SAMPLES = 4;

   // Shadow copy of the block's state
   c420ba_pkg::pix_type                    line_buf [0:MAX_WIDTH-1];
   c420ba_pkg::pix_type                    left_px;
   logic [c420ba_pkg::COORD_W-1:0]         col_cnt;
   logic [c420ba_pkg::COORD_W-1:0]         row_cnt;
   logic [c420ba_pkg::SIZE_W-1:0]          width_reg;
   logic [c420ba_pkg::SIZE_W-1:0]          height_reg;
   c420ba_pkg::rsp_type                    block_q [$];
   int                                     mismatches = 0;

   // zero reads as 1, oversize saturates
   function automatic int clamp_size(input int v, input int limit);
      int s;
      s = (v == 0) ? 1 : v;
      if (s > limit) s = limit;
      if (s > c420ba_pkg::COUNT_LIMIT) s = c420ba_pkg::COUNT_LIMIT;
      return s;
   endfunction

   function automatic int line_slot(input int c);
      return (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
   endfunction

   function automatic c420ba_pkg::rsp_type make_rsp(input int c, input int r,
                                                    input c420ba_pkg::pix_type px,
                                                    input int u, input int v,
                                                    input logic last);
      c420ba_pkg::rsp_type t;
      t.out_col       = c[c420ba_pkg::COORD_W-1:0];
      t.out_row       = r[c420ba_pkg::COORD_W-1:0];
      t.y_out         = px.y;
      t.u_out         = u[c420ba_pkg::SAMPLE_W-1:0];
      t.v_out         = v[c420ba_pkg::SAMPLE_W-1:0];
      t.last_of_block = last;
      return t;
   endfunction

   // Advance the shadow state by one pixel and queue the pixels it completes
   task automatic predict_pixel(input c420ba_pkg::pix_type cur);
      int                  w, h, c, r, su, sv;
      bit                  last_col, last_row;
      c420ba_pkg::pix_type top, tl;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, c420ba_pkg::MAX_HEIGHT);
      c = col_cnt;
      r = row_cnt;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      if (r[0]) begin
         top = line_buf[line_slot(c)];
         if (c[0]) begin
            // full 2x2 block
            tl = line_buf[line_slot(c - 1)];
            su = (int'(tl.u) + int'(top.u) + int'(left_px.u) + int'(cur.u)) / BLOCK_SAMPLES;
            sv = (int'(tl.v) + int'(top.v) + int'(left_px.v) + int'(cur.v)) / BLOCK_SAMPLES;
            block_q.push_back(make_rsp(c - 1, r - 1, tl, su, sv, 1'b0));
            block_q.push_back(make_rsp(c, r - 1, top, su, sv, 1'b0));
            block_q.push_back(make_rsp(c - 1, r, left_px, su, sv, 1'b0));
            block_q.push_back(make_rsp(c, r, cur, su, sv, 1'b1));
         end else if (last_col) begin
            // one column wide: each row counts twice
            su = (2 * (int'(top.u) + int'(cur.u))) / BLOCK_SAMPLES;
            sv = (2 * (int'(top.v) + int'(cur.v))) / BLOCK_SAMPLES;
            block_q.push_back(make_rsp(c, r - 1, top, su, sv, 1'b0));
            block_q.push_back(make_rsp(c, r, cur, su, sv, 1'b1));
         end
      end else if (last_row) begin
         if (c[0]) begin
            // one row high: each pixel counts twice
            su = (2 * (int'(left_px.u) + int'(cur.u))) / BLOCK_SAMPLES;
            sv = (2 * (int'(left_px.v) + int'(cur.v))) / BLOCK_SAMPLES;
            block_q.push_back(make_rsp(c - 1, r, left_px, su, sv, 1'b0));
            block_q.push_back(make_rsp(c, r, cur, su, sv, 1'b1));
         end else if (last_col) begin
            // corner pixel alone
            su = (4 * int'(cur.u)) / BLOCK_SAMPLES;
            sv = (4 * int'(cur.v)) / BLOCK_SAMPLES;
            block_q.push_back(make_rsp(c, r, cur, su, sv, 1'b1));
         end
      end else begin
         line_buf[line_slot(c)] = cur;
      end
      left_px = cur;
      // counters wrap at the last column and row
      if (last_col) begin
         col_cnt = '0;
         row_cnt = last_row ? '0 : row_cnt + 1'b1;
      end else begin
         col_cnt = col_cnt + 1'b1;
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Monitor: result first, then register writes, then the new pixel
   always @(posedge clock) begin : monitor
      c420ba_pkg::rsp_type oldest;
      c420ba_pkg::pix_type cur;
      if (reset) begin
         width_reg  = c420ba_pkg::FRAME_WIDTH_RESET;
         height_reg = c420ba_pkg::FRAME_HEIGHT_RESET;
         col_cnt    = '0;
         row_cnt    = '0;
         left_px    = '0;
         block_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (block_q.size() == 0) begin
               $error("unexpected result transaction at col %0d row %0d",
                      rsp_data.out_col, rsp_data.out_row);
               mismatches++;
            end else begin
               oldest = block_q.pop_front();
               compare_field("out_col", oldest.out_col, rsp_data.out_col);
               compare_field("out_row", oldest.out_row, rsp_data.out_row);
               compare_field("y_out", oldest.y_out, rsp_data.y_out);
               compare_field("u_out", oldest.u_out, rsp_data.u_out);
               compare_field("v_out", oldest.v_out, rsp_data.v_out);
               compare_field("last_of_block", oldest.last_of_block, rsp_data.last_of_block);
            end
         end
         if (csr_wr_en) begin
            case (csr_addr)
               c420ba_pkg::CSR_FRAME_WIDTH:  width_reg  = csr_wdata;
               c420ba_pkg::CSR_FRAME_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            cur.y = req_data.y_in;
            cur.u = req_data.u_in;
            cur.v = req_data.v_in;
            predict_pixel(cur);
         end
      end
      fail_count      <= mismatches;
      pending_results <= block_q.size();
   end

endmodule

FILE: tb/sv/chroma_420_block_average_core_tb.sv
// Top of the 4:2:0 chroma box-average testbench: clock, reset, pixel and
// register stimulus, result back-pressure and the verdict.
// Depends on c420ba_pkg, chroma_420_block_average_core and its checker.
`timescale 1ns / 100ps

module chroma_420_block_average_core_tb;

   localparam int MAX_WIDTH     = 2048;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_PIXELS = 420;
   localparam int CYCLE_LIMIT   = 600000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              csr_wr_en = 1'b0;
   logic [c420ba_pkg::CSR_ADDR_W-1:0] csr_addr  = c420ba_pkg::CSR_FRAME_WIDTH;
   logic [c420ba_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   c420ba_pkg::req_type               req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   c420ba_pkg::rsp_type               rsp_data;
   int                                fail_count;
   int                                pending_results;
   int                                burst_left  = 0;
   int                                cycle_count = 0;
   bit                                hold_request = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   chroma_420_block_average_core #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   chroma_420_block_average_core_check #(.MAX_WIDTH(MAX_WIDTH)) result_check (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_results(pending_results)
   );

   function automatic c420ba_pkg::req_type pixel(input logic [c420ba_pkg::SAMPLE_W-1:0] y,
                                                 input logic [c420ba_pkg::SAMPLE_W-1:0] u,
                                                 input logic [c420ba_pkg::SAMPLE_W-1:0] v);
      c420ba_pkg::req_type px;
      px.y_in = y;
      px.u_in = u;
      px.v_in = v;
      return px;
   endfunction

   // random sample, biased toward the extremes
   function automatic logic [c420ba_pkg::SAMPLE_W-1:0] random_sample();
      logic [c420ba_pkg::SAMPLE_W-1:0] s;
      s = $urandom_range(0, 255);
      case ($urandom_range(0, 7))
         0: s = '0;
         1: s = '1;
         default: ;
      endcase
      return s;
   endfunction

   function automatic c420ba_pkg::req_type random_pixel();
      return pixel(random_sample(), random_sample(), random_sample());
   endfunction

   function automatic int eff_size(input int v);
      if (v == 0) return 1;
      return (v > c420ba_pkg::COUNT_LIMIT) ? c420ba_pkg::COUNT_LIMIT : v;
   endfunction

   // Both frame registers, back to back; block must be idle
   task automatic set_frame_size(input int w, input int h);
      csr_wr_en <= 1'b1;
      csr_addr  <= c420ba_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= w[c420ba_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_addr  <= c420ba_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= h[c420ba_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One pixel transaction; the sender runs in bursts with random gaps
   task automatic send_pixel(input c420ba_pkg::req_type px);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_pixel(random_pixel());
   endtask

   // Drain: wait for every expected result, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result back-pressure: random modes, plus one long hold-off on request
   initial begin : rsp_stall_gen
      stall_mode_type mode;
      int             mode_left;
      bit             hold_done;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               case ($urandom_range(0, 3))
                  0: mode = STALL_NONE;
                  1: mode = STALL_LIGHT;
                  2: mode = STALL_HEAVY;
                  default: mode = STALL_PERIODIC;
               endcase
               mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 1) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((mode_left % 8) < 3);
            endcase
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int done_pixels, w, h, frame_pixels;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // 2x2 block at the sample extremes; chroma sums need flooring
      set_frame_size(2, 2);
      send_pixel(pixel(8'h00, 8'hff, 8'h00));
      send_pixel(pixel(8'hff, 8'hff, 8'h00));
      send_pixel(pixel(8'h00, 8'hff, 8'h00));
      send_pixel(pixel(8'hff, 8'hfe, 8'h01));
      wait_idle();

      // odd last column, odd last row and the lone corner pixel
      set_frame_size(3, 3);
      send_random(9);
      wait_idle();

      // zero sizes read as a 1x1 frame
      set_frame_size(0, 0);
      send_pixel(pixel(8'hff, 8'h01, 8'h03));
      wait_idle();

      // width shrinks in mid frame, column counter already past the new edge
      set_frame_size(4, 3);
      send_random(6);
      wait_idle();
      set_frame_size(2, 3);
      send_random(3);
      wait_idle();

      // Random frames, mostly small; one larger frame rides out a long hold-off
      done_pixels = 0;
      while (done_pixels < RANDOM_PIXELS) begin
         if (!hold_request && done_pixels >= 150) begin
            w = 16;
            h = 8;
         end else if ($urandom_range(0, 7) == 0) begin
            w = $urandom_range(10, 40);
            h = $urandom_range(1, 4);
         end else begin
            w = $urandom_range(0, 9);
            h = $urandom_range(0, 7);
         end
         set_frame_size(w, h);
         if (w == 16 && h == 8) hold_request = 1'b1;
         frame_pixels = eff_size(w) * eff_size(h);
         send_random(frame_pixels);
         wait_idle();
         done_pixels += frame_pixels;
      end

      // saturating sizes: the start of a full-width row, then of a
      // full-height column, each closed by shrinking the frame to 1x1
      set_frame_size(4095, 1);
      send_random(8);
      wait_idle();
      set_frame_size(1, 1);
      send_random(1);
      wait_idle();
      set_frame_size(1, 4095);
      send_random(8);
      wait_idle();
      set_frame_size(1, 1);
      send_random(1);
      wait_idle();

      if (fail_count == 0 && pending_results == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
